[hdl/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside of reset
`define SFA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sfa assertion failed");

// checked on every rising edge, reset included
`define SFA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sfa assertion failed");

`endif

[hdl/sfa_pkg.sv]
package sfa_pkg;

    localparam int DATA_W = 32;
    // dividend magnitude left aligned: 32 magnitude bits plus the widest fraction
    localparam int DVD_W  = 62;
    localparam int ALIGN_W = DVD_W - DATA_W;

    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    // first stage contents
    typedef struct packed {
        op_t                        op;
        logic signed [DATA_W-1:0]   sum_res;
        logic signed [2*DATA_W-1:0] prod;
        logic [DVD_W-1:0]           dvd;
        logic [DATA_W-1:0]          dvs;
        logic                       neg;
        logic                       a_pos;
    } front_t;

    // contents handed from one divider cell to the next
    typedef struct packed {
        op_t                      op;
        logic signed [DATA_W-1:0] res;
        logic [DATA_W-1:0]        rem;
        logic [DVD_W-1:0]         dvd;
        logic [DVD_W-1:0]         quo;
        logic [DATA_W-1:0]        dvs;
        logic                     neg;
        logic                     a_pos;
    } cell_t;

endpackage

[hdl/sfa_front.sv]
module sfa_front #(
    parameter int FRAC_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          op,
    input  logic signed [sfa_pkg::DATA_W-1:0]   operand_a,
    input  logic signed [sfa_pkg::DATA_W-1:0]   operand_b,
    output logic                                dn_valid,
    output sfa_pkg::cell_t                      dn_data,
    input  logic                                dn_ready
);
    import sfa_pkg::*;

    logic                       valid_reg;
    front_t                     data_reg;
    front_t                     data_next;
    logic signed [DATA_W:0]     sum_c;
    logic signed [2*DATA_W-1:0] prod_sh;
    logic signed [DATA_W-1:0]   mul_res;

    assign in_ready = !valid_reg || dn_ready;

    always_comb
    begin
        if (op_t'(op) == OP_SUB)
            sum_c = {operand_a[DATA_W-1], operand_a} - {operand_b[DATA_W-1], operand_b};
        else
            sum_c = {operand_a[DATA_W-1], operand_a} + {operand_b[DATA_W-1], operand_b};

        data_next.op = op_t'(op);
        if (sum_c[DATA_W] != sum_c[DATA_W-1])
            data_next.sum_res = sum_c[DATA_W] ? S32_MIN : S32_MAX;
        else
            data_next.sum_res = sum_c[DATA_W-1:0];
        data_next.prod  = (2*DATA_W)'(operand_a) * (2*DATA_W)'(operand_b);
        data_next.dvd   = {(operand_a[DATA_W-1] ? DATA_W'(-operand_a) : DATA_W'(operand_a)),
                           {ALIGN_W{1'b0}}};
        data_next.dvs   = operand_b[DATA_W-1] ? DATA_W'(-operand_b) : DATA_W'(operand_b);
        data_next.neg   = operand_a[DATA_W-1] ^ operand_b[DATA_W-1];
        data_next.a_pos = !operand_a[DATA_W-1] && (operand_a != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    // finish the multiply: floor shift, then clamp
    always_comb
    begin
        prod_sh = data_reg.prod >>> FRAC_BITS;
        if ((prod_sh[2*DATA_W-1:DATA_W-1] == '0) || (prod_sh[2*DATA_W-1:DATA_W-1] == '1))
            mul_res = prod_sh[DATA_W-1:0];
        else
            mul_res = prod_sh[2*DATA_W-1] ? S32_MIN : S32_MAX;

        dn_data.op    = data_reg.op;
        dn_data.res   = (data_reg.op == OP_MUL) ? mul_res : data_reg.sum_res;
        dn_data.rem   = '0;
        dn_data.dvd   = data_reg.dvd;
        dn_data.quo   = '0;
        dn_data.dvs   = data_reg.dvs;
        dn_data.neg   = data_reg.neg;
        dn_data.a_pos = data_reg.a_pos;
    end

    assign dn_valid = valid_reg;

endmodule

[hdl/sfa_div_cell.sv]
module sfa_div_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    output logic           up_ready,
    input  sfa_pkg::cell_t up_data,
    output logic           dn_valid,
    output sfa_pkg::cell_t dn_data,
    input  logic           dn_ready
);
    import sfa_pkg::*;

    logic              valid_reg;
    cell_t             data_reg;
    cell_t             data_next;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;
    logic              ge;

    assign up_ready = !valid_reg || dn_ready;

    // one restoring division step: one quotient bit
    always_comb
    begin
        trial = {up_data.rem, up_data.dvd[DVD_W-1]};
        diff  = trial - {1'b0, up_data.dvs};
        ge    = (trial >= {1'b0, up_data.dvs});

        data_next     = up_data;
        data_next.rem = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        data_next.dvd = {up_data.dvd[DVD_W-2:0], 1'b0};
        data_next.quo = {up_data.quo[DVD_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

[hdl/sfa_back.sv]
module sfa_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              up_valid,
    output logic                              up_ready,
    input  sfa_pkg::cell_t                    up_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [sfa_pkg::DATA_W-1:0] result_value
);
    import sfa_pkg::*;

    logic                     valid_reg;
    logic signed [DATA_W-1:0] res_reg;
    logic signed [DATA_W-1:0] res_next;
    logic signed [DATA_W-1:0] div_res;
    logic                     q_hi;

    assign up_ready = !valid_reg || !out_stall;

    // sign and clamp of the quotient magnitude
    always_comb
    begin
        q_hi = (up_data.quo[DVD_W-1:DATA_W] != '0);
        if (up_data.dvs == '0)
            div_res = up_data.a_pos ? S32_MAX : S32_MIN;
        else if (up_data.neg)
        begin
            if (q_hi || (up_data.quo[DATA_W-1] && (up_data.quo[DATA_W-2:0] != '0)))
                div_res = S32_MIN;
            else
                div_res = -up_data.quo[DATA_W-1:0];
        end
        else
        begin
            if (q_hi || up_data.quo[DATA_W-1])
                div_res = S32_MAX;
            else
                div_res = up_data.quo[DATA_W-1:0];
        end

        case (up_data.op)
            OP_DIV:  res_next = div_res;
            default: res_next = up_data.res;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            res_reg <= res_next;
    end

    assign out_valid    = valid_reg;
    assign result_value = res_reg;

endmodule

[hdl/saturating_fixed_point_alu.sv]
// saturating fixed-point alu, signed 32-bit raw values with FRAC_BITS fraction bits
// input channel: in_valid / in_stall with op, operand_a, operand_b; a transfer
//   happens on a rising edge with in_valid high and in_stall low
// output channel: out_valid / out_stall with result_value, one result per input
// op: add and subtract work on the raw values, multiply keeps the full product
//   and floor-shifts it by FRAC_BITS, divide truncates toward zero; every
//   result is clamped to the signed 32-bit range, divide by zero gives the
//   maximum for a positive dividend and the minimum otherwise
// path: the operand stage, then the divider row with one quotient bit per cell,
//   32 + FRAC_BITS cells, then the output register; all ops take the same path
// throughput: one transfer per cycle while out_stall does not hold the pipeline, in order
// stall: every stage holds only while it is full and the one after it is held,
//   so bubbles close up and a new item is taken while a result waits
// reset: clears all stage valid bits, the pipeline comes up empty
module saturating_fixed_point_alu #(
    parameter int FRAC_BITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        op,
    input  logic signed [sfa_pkg::DATA_W-1:0] operand_a,
    input  logic signed [sfa_pkg::DATA_W-1:0] operand_b,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [sfa_pkg::DATA_W-1:0] result_value
);
    import sfa_pkg::*;

    // one cell per quotient bit
    localparam int NCELL = DATA_W + FRAC_BITS;

    logic  in_ready;
    logic  cv [0:NCELL];
    logic  cr [0:NCELL];
    cell_t cd [0:NCELL];

    assign in_stall = !in_ready;

    // operand stage: saturated add/sub, product, divide magnitudes
    sfa_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .dn_valid  (cv[0]),
        .dn_data   (cd[0]),
        .dn_ready  (cr[0])
    );

    // divider row, the other ops ride along unchanged
    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        sfa_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (cv[i]),
            .up_ready (cr[i]),
            .up_data  (cd[i]),
            .dn_valid (cv[i+1]),
            .dn_data  (cd[i+1]),
            .dn_ready (cr[i+1])
        );
    end

    // quotient sign and clamp, output register
    sfa_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_valid     (cv[NCELL]),
        .up_ready     (cr[NCELL]),
        .up_data      (cd[NCELL]),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value)
    );

endmodule

[hdl/sfa_checker.sv]
`include "assert_macros.svh"

module sfa_checker #(
    parameter int FRAC_BITS = 8
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] result_value
);
    localparam int DEPTH = 34 + FRAC_BITS;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic             in_xfer;
    logic             out_xfer;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;

    // items taken in but not yet handed out
    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_xfer && !out_xfer)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (!in_xfer && out_xfer)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // input is held back only when the output is full and held
    `SFA_ASSERT(a_stall_cause, clk, rst_n, in_stall |-> (out_valid && out_stall))
    // no result without an item in flight
    `SFA_ASSERT(a_no_phantom, clk, rst_n, out_valid |-> (cnt_reg != '0))
    // pipeline never holds more items than it has stages
    `SFA_ASSERT_ALWAYS(a_depth, clk, !rst_n || (cnt_reg <= CNT_W'(DEPTH)))
    // held result stays put
    `SFA_ASSERT(a_out_hold, clk, rst_n,
        (out_valid && out_stall) |=> (out_valid && $stable(result_value)))

endmodule

bind saturating_fixed_point_alu sfa_checker #(.FRAC_BITS(FRAC_BITS)) u_sfa_checker (.*);

[tb/tb_saturating_fixed_point_alu.sv]
module tb_saturating_fixed_point_alu;

    import sfa_pkg::*;

    // fraction bit count of the instance under test
    localparam int FRAC_BITS = 8;
    // input transfer to out_valid, equal to the number of pipeline stages
    localparam int PIPE_LATENCY = 34 + FRAC_BITS;
    // watchdog limit for the whole run, with a wide margin
    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_PER_PHASE = 320;

    // one pending transfer: the operation as sent and the value it must produce
    typedef struct {
        op_t                      code;
        logic signed [DATA_W-1:0] lhs;
        logic signed [DATA_W-1:0] rhs;
        logic signed [DATA_W-1:0] result;
    } alu_expect_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [1:0]                op = 2'd0;
    logic signed [DATA_W-1:0]  operand_a = '0;
    logic signed [DATA_W-1:0]  operand_b = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [DATA_W-1:0]  result_value;

    // results still owed by the block, oldest first
    alu_expect_t pending_results[$];
    alu_expect_t oldest_pending;

    int error_count = 0;
    int cycle_count = 0;
    // percent chance per cycle that the sender idles or the receiver stalls
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    saturating_fixed_point_alu #(
        .FRAC_BITS(FRAC_BITS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .operand_a(operand_a),
        .operand_b(operand_b),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .result_value(result_value)
    );

    always #5 clk = ~clk;

    // saturated fixed-point result of one operation, worked out on 64 bits
    function automatic logic signed [DATA_W-1:0] fixed_point_result(
        input op_t                      code,
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        longint wide_a;
        longint wide_b;
        longint full;
        wide_a = longint'(a);
        wide_b = longint'(b);
        case (code)
            OP_ADD: full = wide_a + wide_b;
            OP_SUB: full = wide_a - wide_b;
            // arithmetic shift of the full product rounds toward minus infinity
            OP_MUL: full = (wide_a * wide_b) >>> FRAC_BITS;
            default:
            begin
                // divide by zero: maximum for a positive dividend, minimum otherwise
                if (wide_b == 0)
                    full = (wide_a > 0) ? longint'(S32_MAX) : longint'(S32_MIN);
                else
                    full = (wide_a <<< FRAC_BITS) / wide_b;
            end
        endcase
        if (full > longint'(S32_MAX))
            full = longint'(S32_MAX);
        else if (full < longint'(S32_MIN))
            full = longint'(S32_MIN);
        return full[DATA_W-1:0];
    endfunction

    // operand mix: plain random bits, small values, values near one, extremes,
    // and random magnitudes of every size with either sign
    function automatic logic signed [DATA_W-1:0] random_operand();
        int                       pick;
        logic signed [DATA_W-1:0] value;
        pick = $urandom_range(7);
        case (pick)
            0, 1, 2: value = $urandom;
            3:       value = int'($urandom_range(2047)) - 1024;
            4:       value = int'($urandom_range(131071)) - 65536;
            5:
            begin
                case ($urandom_range(4))
                    0: value = S32_MAX;
                    1: value = S32_MIN;
                    2: value = 0;
                    3: value = 1;
                    default: value = -1;
                endcase
            end
            default:
            begin
                value = $urandom >> $urandom_range(31);
                if ($urandom_range(1) == 1)
                    value = -value;
            end
        endcase
        return value;
    endfunction

    task automatic report_mismatch(input string detail);
        $display("%0t: mismatch: %s", $time, detail);
        error_count++;
    endtask

    // one input transfer: idle gaps with junk payload, then hold the item
    // until a rising edge sees in_valid high and in_stall low
    task automatic send_operation(
        input op_t                      code,
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        alu_expect_t item;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            // valid low, so the payload is free to wander
            in_valid  <= 1'b0;
            op        <= 2'($urandom);
            operand_a <= $urandom;
            operand_b <= $urandom;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        op        <= code;
        operand_a <= a;
        operand_b <= b;
        do
            @(posedge clk);
        while (in_stall);
        item.code   = code;
        item.lhs    = a;
        item.rhs    = b;
        item.result = fixed_point_result(code, a, b);
        pending_results.push_back(item);
    endtask

    // random operations; a divide gets a zero divisor now and then
    task automatic run_random_operations(input int count);
        op_t                      code;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        for (int n = 0; n < count; n++)
        begin
            code = op_t'($urandom_range(3));
            a = random_operand();
            b = random_operand();
            if (code == OP_DIV && $urandom_range(15) == 0)
                b = 0;
            send_operation(code, a, b);
        end
    endtask

    // corner cases of every operation, back to back
    task automatic test_directed_corners();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // add and subtract saturate at both ends
        send_operation(OP_ADD, S32_MAX, 32'sd1);
        send_operation(OP_ADD, S32_MIN, -32'sd1);
        send_operation(OP_ADD, S32_MIN, S32_MAX);
        send_operation(OP_ADD, 32'sd0, 32'sd0);
        send_operation(OP_SUB, S32_MIN, 32'sd1);
        send_operation(OP_SUB, S32_MAX, -32'sd1);
        send_operation(OP_SUB, 32'sd0, S32_MIN);
        send_operation(OP_SUB, -32'sd1, S32_MAX);
        // multiply overflow, unity and floor rounding of negative products
        send_operation(OP_MUL, S32_MAX, S32_MAX);
        send_operation(OP_MUL, S32_MIN, S32_MIN);
        send_operation(OP_MUL, S32_MIN, S32_MAX);
        send_operation(OP_MUL, 32'sd256, 32'sd256);
        send_operation(OP_MUL, -32'sd1, 32'sd1);
        send_operation(OP_MUL, -32'sd3, 32'sd3);
        // divide by zero for positive, zero and negative dividends
        send_operation(OP_DIV, 32'sd5, 32'sd0);
        send_operation(OP_DIV, 32'sd0, 32'sd0);
        send_operation(OP_DIV, -32'sd5, 32'sd0);
        send_operation(OP_DIV, S32_MIN, 32'sd0);
        // quotient overflow, truncation toward zero, tiny quotients
        send_operation(OP_DIV, S32_MIN, -32'sd1);
        send_operation(OP_DIV, S32_MAX, 32'sd1);
        send_operation(OP_DIV, S32_MIN, 32'sd1);
        send_operation(OP_DIV, 32'sd256, 32'sd256);
        send_operation(OP_DIV, -32'sd1, 32'sd3);
        send_operation(OP_DIV, 32'sd1, S32_MAX);
        send_operation(OP_DIV, -32'sd7, S32_MIN);
    endtask

    task automatic test_random_back_to_back();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_operations(RANDOM_PER_PHASE);
    endtask

    task automatic test_random_sparse_sender();
        send_idle_pct  = 81;
        recv_stall_pct = 0;
        run_random_operations(RANDOM_PER_PHASE);
    endtask

    task automatic test_random_slow_receiver();
        send_idle_pct  = 0;
        recv_stall_pct = 81;
        run_random_operations(RANDOM_PER_PHASE);
    endtask

    task automatic test_random_both_idle();
        send_idle_pct  = 9;
        recv_stall_pct = 9;
        run_random_operations(RANDOM_PER_PHASE);
    endtask

    // a burst, a full drain of the pipeline, then a fresh burst into it empty
    task automatic test_drain_pause();
        send_idle_pct  = 0;
        recv_stall_pct = 50;
        run_random_operations(20);
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        run_random_operations(20);
    endtask

    // receiver stall, redrawn each falling edge
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // every output transfer is matched against the oldest pending result
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result %h", result_value));
            else
            begin
                oldest_pending = pending_results.pop_front();
                if (result_value !== oldest_pending.result)
                    report_mismatch($sformatf("%s a=%h b=%h result_value got %h want %h",
                        oldest_pending.code.name(), oldest_pending.lhs,
                        oldest_pending.rhs, result_value, oldest_pending.result));
            end
        end
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout with %0d results pending", pending_results.size());
            $display("tb_saturating_fixed_point_alu: FAIL");
            $finish;
        end
    end

    initial
    begin
        // reset held low at the start, released away from the rising edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_corners();
        test_random_back_to_back();
        test_random_sparse_sender();
        test_drain_pause();
        test_random_slow_receiver();
        test_random_both_idle();

        @(negedge clk);
        in_valid <= 1'b0;
        recv_stall_pct = 0;
        wait (pending_results.size() == 0);
        // watch for stray results after the last expected one
        repeat (PIPE_LATENCY + 20) @(posedge clk);

        if (error_count == 0)
            $display("tb_saturating_fixed_point_alu: PASS");
        else
            $display("tb_saturating_fixed_point_alu: FAIL");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/sfa_pkg.sv
hdl/sfa_front.sv
hdl/sfa_div_cell.sv
hdl/sfa_back.sv
hdl/saturating_fixed_point_alu.sv
hdl/sfa_checker.sv
tb/tb_saturating_fixed_point_alu.sv
